// File: hdl/clse_pkg.sv
// ----------------------------------------------------------------------------
// clse_pkg
// shared types, constants and codes of the character display shadow text engine
// ----------------------------------------------------------------------------
`default_nettype none

package clse_pkg;

   localparam int CHARS_PER_LINE = 20;
   localparam int TEXT_SIZE      = 2 * CHARS_PER_LINE;
   localparam int ADDR_W         = $clog2(TEXT_SIZE);
   localparam int COL_W          = 6;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 1;

   localparam logic [7:0] CTRL_CMD   = 8'h00;
   localparam logic [7:0] CTRL_DATA  = 8'h40;
   localparam logic [7:0] ROW1_BASE  = 8'h40;
   localparam logic [7:0] CMD_CURSOR = 8'h80;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] NEWLINE    = 8'h0A;
   localparam logic [7:0] PRINT_LO   = 8'h20;
   localparam logic [7:0] PRINT_HI   = 8'h7E;

   localparam logic [2:0] KIND_CHAR   = 3'd0;
   localparam logic [2:0] KIND_POS    = 3'd1;
   localparam logic [2:0] KIND_CLEAR  = 3'd2;
   localparam logic [2:0] KIND_UPDATE = 3'd3;
   localparam logic [2:0] KIND_BUS    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_DOUBLE_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_AUTO_UPDATE   = 1'b1;

   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_PUT   = 3'd1;
   localparam logic [2:0] OP_NL    = 3'd2;
   localparam logic [2:0] OP_CLEAR = 3'd3;
   localparam logic [2:0] OP_POS   = 3'd4;
   localparam logic [2:0] OP_BUS   = 3'd5;

   localparam logic [2:0] EM_CTRL_CMD  = 3'd0;
   localparam logic [2:0] EM_CUR_LINE  = 3'd1;
   localparam logic [2:0] EM_CTRL_DATA = 3'd2;
   localparam logic [2:0] EM_CHAR      = 3'd3;
   localparam logic [2:0] EM_CUR_POS   = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] char_code;
      logic       end_of_text;
      logic [1:0] row_sel;
      logic [5:0] col_sel;
      logic       bus_failed;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       end_of_transfer;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic       fill_wr;
      logic       upd_begin;
      logic       line_next;
      logic       idx_clr;
      logic       idx_inc;
      logic       diff_acc;
      logic       shown_wr;
      logic       dirty_set;
      logic       dirty_clr;
      logic       emit;
      logic [2:0] emit_sel;
      logic       emit_eot;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic fill_end;
      logic idx_end;
      logic line_need;
      logic line_one;
      logic dirty;
      logic bus_err;
      logic auto_update;
   } sts_type;

endpackage

`default_nettype wire

// File: hdl/clse_ctrl.sv
// ----------------------------------------------------------------------------
// clse_ctrl
// sequencer for text edits, line fills and display updates
// ----------------------------------------------------------------------------
`default_nettype none

module clse_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire clse_pkg::req_type req_data,
   input  wire clse_pkg::sts_type sts,
   output logic                  busy,
   output clse_pkg::cmd_type     cmd
);
   import clse_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FILL   = 4'd1;
   localparam logic [3:0] S_CMP_RD = 4'd2;
   localparam logic [3:0] S_CMP_CK = 4'd3;
   localparam logic [3:0] S_H0     = 4'd4;
   localparam logic [3:0] S_H1     = 4'd5;
   localparam logic [3:0] S_H2     = 4'd6;
   localparam logic [3:0] S_D_RD   = 4'd7;
   localparam logic [3:0] S_D_OUT  = 4'd8;
   localparam logic [3:0] S_C0     = 4'd9;
   localparam logic [3:0] S_C1     = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       upd_after_ff, upd_after_in;
   logic       printable;
   logic       pos_ok;

   assign busy      = (state_ff != S_IDLE);
   assign printable = (req_data.char_code >= PRINT_LO) && (req_data.char_code <= PRINT_HI);
   assign pos_ok    = (req_data.row_sel < 2'd2) &&
                      (req_data.col_sel < COL_W'(CHARS_PER_LINE));

   always_comb begin
      state_in     = state_ff;
      upd_after_in = upd_after_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.kind)
                  KIND_CHAR: begin
                     if (req_data.char_code == NEWLINE) begin
                        cmd.op       = OP_NL;
                        upd_after_in = req_data.end_of_text & sts.auto_update;
                        state_in     = S_FILL;
                     end else begin
                        if (printable) begin
                           cmd.op = OP_PUT;
                        end
                        if (req_data.end_of_text && sts.auto_update) begin
                           cmd.upd_begin = 1'b1;
                           state_in      = S_CMP_RD;
                        end
                     end
                  end
                  KIND_POS: begin
                     if (pos_ok) begin
                        cmd.op = OP_POS;
                        if (sts.auto_update) begin
                           cmd.upd_begin = 1'b1;
                           state_in      = S_CMP_RD;
                        end
                     end
                  end
                  KIND_CLEAR: begin
                     cmd.op       = OP_CLEAR;
                     upd_after_in = sts.auto_update;
                     state_in     = S_FILL;
                  end
                  KIND_UPDATE: begin
                     cmd.upd_begin = 1'b1;
                     state_in      = S_CMP_RD;
                  end
                  KIND_BUS: begin
                     cmd.op = OP_BUS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FILL: begin
            cmd.fill_wr = 1'b1;
            if (sts.fill_end) begin
               if (upd_after_ff) begin
                  cmd.upd_begin = 1'b1;
                  state_in      = S_CMP_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CMP_RD: begin
            state_in = S_CMP_CK;
         end
         S_CMP_CK: begin
            if (!sts.idx_end) begin
               cmd.diff_acc = 1'b1;
               cmd.idx_inc  = 1'b1;
               state_in     = S_CMP_RD;
            end else if (sts.line_need) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_H0;
            end else if (!sts.line_one) begin
               cmd.line_next = 1'b1;
               state_in      = S_CMP_RD;
            end else if (sts.dirty || sts.bus_err) begin
               state_in = S_C0;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_H0: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_CTRL_CMD;
            state_in     = S_H1;
         end
         S_H1: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_CUR_LINE;
            cmd.emit_eot = 1'b1;
            state_in     = S_H2;
         end
         S_H2: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_CTRL_DATA;
            state_in     = S_D_RD;
         end
         S_D_RD: begin
            state_in = S_D_OUT;
         end
         S_D_OUT: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_CHAR;
            cmd.emit_eot = sts.idx_end;
            cmd.shown_wr = 1'b1;
            if (!sts.idx_end) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_D_RD;
            end else begin
               cmd.dirty_set = 1'b1;
               if (!sts.line_one) begin
                  cmd.line_next = 1'b1;
                  state_in      = S_CMP_RD;
               end else begin
                  state_in = S_C0;
               end
            end
         end
         S_C0: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_CTRL_CMD;
            state_in     = S_C1;
         end
         S_C1: begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = EM_CUR_POS;
            cmd.emit_eot  = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.dirty_clr = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         upd_after_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upd_after_ff <= upd_after_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/clse_dpath.sv
// ----------------------------------------------------------------------------
// clse_dpath
// text images, cursor, config registers and transfer byte output
// ----------------------------------------------------------------------------
`default_nettype none

module clse_dpath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire clse_pkg::req_type                    req_data,
   input  wire clse_pkg::cmd_type                    cmd,
   input  wire logic                                 csr_we,
   input  wire logic [clse_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [clse_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output clse_pkg::sts_type                         sts,
   output logic                                      rsp_valid,
   output clse_pkg::rsp_type                         rsp_data
);
   import clse_pkg::*;

   logic [7:0]           pend_mem [TEXT_SIZE];
   logic [7:0]           shown_mem [TEXT_SIZE];
   logic [TEXT_SIZE-1:0] pend_vld_ff;
   logic [TEXT_SIZE-1:0] shown_vld_ff;
   logic [7:0]           pend_q_ff;
   logic [7:0]           shown_q_ff;
   logic                 pend_qv_ff;
   logic                 shown_qv_ff;

   logic                 cursor_row_ff;
   logic [COL_W-1:0]     cursor_col_ff;
   logic                 dirty_ff;
   logic                 bus_err_ff;
   logic                 double_height_ff;
   logic                 auto_update_ff;
   logic [ADDR_W-1:0]    fill_addr_ff;
   logic [ADDR_W-1:0]    fill_end_ff;
   logic                 line_ff;
   logic [COL_W-1:0]     idx_ff;
   logic                 diff_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic [ADDR_W-1:0]    cur_pos;
   logic [ADDR_W-1:0]    row_last;
   logic [ADDR_W-1:0]    rd_addr;
   logic [COL_W-1:0]     col_inc;
   logic                 wrap;
   logic                 next_row;
   logic                 pend_we;
   logic [ADDR_W-1:0]    pend_wa;
   logic [7:0]           pend_wd;
   logic [7:0]           pend_val;
   logic [7:0]           shown_val;
   logic                 mismatch;
   logic [7:0]           emit_byte;

   assign cur_pos  = cursor_row_ff ? ADDR_W'(CHARS_PER_LINE) + ADDR_W'(cursor_col_ff)
                                   : ADDR_W'(cursor_col_ff);
   assign row_last = cursor_row_ff ? ADDR_W'(TEXT_SIZE - 1) : ADDR_W'(CHARS_PER_LINE - 1);
   assign rd_addr  = line_ff ? ADDR_W'(CHARS_PER_LINE) + ADDR_W'(idx_ff) : ADDR_W'(idx_ff);
   assign col_inc  = cursor_col_ff + COL_W'(1);
   assign wrap     = (col_inc == COL_W'(CHARS_PER_LINE));
   assign next_row = double_height_ff ? cursor_row_ff : ~cursor_row_ff;

   assign pend_we  = cmd.fill_wr || (cmd.op == OP_PUT);
   assign pend_wa  = cmd.fill_wr ? fill_addr_ff : cur_pos;
   assign pend_wd  = cmd.fill_wr ? SPACE_CHAR : req_data.char_code;

   assign pend_val  = pend_qv_ff ? pend_q_ff : 8'h00;
   assign shown_val = shown_qv_ff ? shown_q_ff : 8'h00;
   assign mismatch  = (pend_val != shown_val);

   assign sts.fill_end    = (fill_addr_ff == fill_end_ff);
   assign sts.idx_end     = (idx_ff == COL_W'(CHARS_PER_LINE - 1));
   assign sts.line_need   = diff_ff | mismatch | bus_err_ff;
   assign sts.line_one    = line_ff;
   assign sts.dirty       = dirty_ff;
   assign sts.bus_err     = bus_err_ff;
   assign sts.auto_update = auto_update_ff;

   always_comb begin
      unique case (cmd.emit_sel)
         EM_CTRL_CMD:  emit_byte = CTRL_CMD;
         EM_CUR_LINE:  emit_byte = CMD_CURSOR | (line_ff ? ROW1_BASE : 8'h00);
         EM_CTRL_DATA: emit_byte = CTRL_DATA;
         EM_CHAR:      emit_byte = pend_val;
         EM_CUR_POS:   emit_byte = CMD_CURSOR | (cursor_row_ff ? ROW1_BASE : 8'h00) |
                                   {2'b00, cursor_col_ff};
         default:      emit_byte = CTRL_CMD;
      endcase
   end

   // text images
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_wa] <= pend_wd;
      end
      if (cmd.shown_wr) begin
         shown_mem[rd_addr] <= pend_val;
      end
      pend_q_ff  <= pend_mem[rd_addr];
      shown_q_ff <= shown_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff  <= '0;
         shown_vld_ff <= '0;
         pend_qv_ff   <= 1'b0;
         shown_qv_ff  <= 1'b0;
      end else begin
         if (pend_we) begin
            pend_vld_ff[pend_wa] <= 1'b1;
         end
         if (cmd.shown_wr) begin
            shown_vld_ff[rd_addr] <= 1'b1;
         end
         pend_qv_ff  <= pend_vld_ff[rd_addr];
         shown_qv_ff <= shown_vld_ff[rd_addr];
      end
   end

   // cursor, flags and config
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff    <= 1'b0;
         cursor_col_ff    <= '0;
         dirty_ff         <= 1'b0;
         bus_err_ff       <= 1'b0;
         double_height_ff <= 1'b0;
         auto_update_ff   <= 1'b0;
         fill_addr_ff     <= '0;
         fill_end_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_DOUBLE_HEIGHT: double_height_ff <= csr_wdata[0];
               REG_AUTO_UPDATE:   auto_update_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (cmd.fill_wr) begin
            fill_addr_ff <= fill_addr_ff + ADDR_W'(1);
         end
         if (cmd.dirty_set) begin
            dirty_ff <= 1'b1;
         end else if (cmd.dirty_clr) begin
            dirty_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_PUT: begin
               if (wrap) begin
                  cursor_col_ff <= '0;
                  cursor_row_ff <= next_row;
               end else begin
                  cursor_col_ff <= col_inc;
               end
            end
            OP_NL: begin
               fill_addr_ff  <= cur_pos;
               fill_end_ff   <= row_last;
               cursor_col_ff <= '0;
               cursor_row_ff <= next_row;
            end
            OP_CLEAR: begin
               fill_addr_ff  <= '0;
               fill_end_ff   <= ADDR_W'(TEXT_SIZE - 1);
               cursor_col_ff <= '0;
               cursor_row_ff <= 1'b0;
            end
            OP_POS: begin
               cursor_row_ff <= req_data.row_sel[0];
               cursor_col_ff <= req_data.col_sel;
               dirty_ff      <= 1'b1;
            end
            OP_BUS: begin
               bus_err_ff <= req_data.bus_failed;
            end
            default: begin
            end
         endcase
      end
   end

   // update walk
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= 1'b0;
         idx_ff  <= '0;
         diff_ff <= 1'b0;
      end else begin
         if (cmd.upd_begin) begin
            line_ff <= 1'b0;
            idx_ff  <= '0;
            diff_ff <= 1'b0;
         end else if (cmd.line_next) begin
            line_ff <= 1'b1;
            idx_ff  <= '0;
            diff_ff <= 1'b0;
         end else begin
            if (cmd.idx_clr) begin
               idx_ff <= '0;
            end else if (cmd.idx_inc) begin
               idx_ff <= idx_ff + COL_W'(1);
            end
            if (cmd.diff_acc) begin
               diff_ff <= diff_ff | mismatch;
            end
         end
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      rsp_data_ff.tx_byte         <= emit_byte;
      rsp_data_ff.end_of_transfer <= cmd.emit_eot;
      rsp_data_ff.last            <= cmd.emit_last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/char_lcd_shadow_text_engine_top.sv
// ----------------------------------------------------------------------------
// char_lcd_shadow_text_engine_top
// two-line character shadow buffer turning text into controller transfer bytes
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   start, busy, req_data               beat when start & !busy
//  response  rsp_valid, rsp_data                 one-cycle strobe, no stall
//  csr       csr_we, csr_index, csr_wdata        write when csr_we
//
//  bus status beats leave the engine idle, as do character and position beats
//  that start no fill or update; newline fills the rest of the cursor row and
//  clear both rows with spaces; update compares the lines column by column,
//  sends changed lines and the cursor; both text images sit in single-port-read
//  memories; synchronous reset, no clearing pass; response beats cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_shadow_text_engine_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire clse_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   output clse_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [clse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [clse_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import clse_pkg::*;

   cmd_type cmd;
   sts_type sts;

   clse_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd)
   );

   clse_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hdl/clse_checker.sv
// ----------------------------------------------------------------------------
// clse_checker
// port-level checks of the shadow text engine
// ----------------------------------------------------------------------------
`default_nettype none

module clse_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire clse_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire clse_pkg::rsp_type rsp_data
);
   import clse_pkg::*;

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("final beat while still busy");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("non-final beat after going idle");

   a_last_eot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.end_of_transfer)
      else $error("final beat does not end a transfer");

   a_bus_quick: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.kind == KIND_BUS |=> !busy && !rsp_valid)
      else $error("bus status beat caused work");

   a_reset: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind char_lcd_shadow_text_engine_top clse_checker u_clse_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: bench/tb_char_lcd_shadow_text_engine_top.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_shadow_text_engine_top
// self-checking bench: directed and random text, cursor, clear, update and bus
// status beats under several register settings, each response beat compared
// against an in-bench model of the shadow buffer and its transfer sequence
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_char_lcd_shadow_text_engine_top;
   import clse_pkg::*;

   localparam int QUIET_CYC   = 100;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic [1:0] {ENT_REQ, ENT_CSR, ENT_DRAIN} ent_kind_type;

   typedef struct {
      ent_kind_type            what;
      req_type                 r;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   val;
   } work_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_type                   req_data;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   work_type  work_q[$];
   rsp_type   tx_expect_q[$];
   logic [7:0] pend_img[TEXT_SIZE];
   logic [7:0] shown_img[TEXT_SIZE];
   logic       cur_row;
   logic [5:0] cur_col;
   logic       cur_dirty;
   logic       bus_err;
   logic       dbl_height;
   logic       auto_upd;
   logic       took;
   int         gap;
   int         quiet;
   int         cycles;
   int         errors;
   int         beats_in;
   int         bytes_out;

   char_lcd_shadow_text_engine_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0d: %s", cycles, msg);
      errors++;
   endtask

   task automatic push_byte(input logic [7:0] b, input logic eot);
      rsp_type x;
      x.tx_byte = b;
      x.end_of_transfer = eot;
      x.last = 1'b0;
      tx_expect_q.push_back(x);
   endtask

   task automatic push_cursor(input logic row, input logic [5:0] col);
      push_byte(CTRL_CMD, 1'b0);
      push_byte(CMD_CURSOR | (row ? ROW1_BASE : 8'h00) | {2'b00, col}, 1'b1);
   endtask

   task automatic model_update();
      logic differs;
      for (int ln = 0; ln < 2; ln++) begin
         differs = 1'b0;
         for (int i = 0; i < CHARS_PER_LINE; i++)
            if (pend_img[ln*CHARS_PER_LINE+i] != shown_img[ln*CHARS_PER_LINE+i])
               differs = 1'b1;
         if (bus_err || differs) begin
            push_cursor(ln[0], 6'd0);
            push_byte(CTRL_DATA, 1'b0);
            for (int i = 0; i < CHARS_PER_LINE; i++) begin
               push_byte(pend_img[ln*CHARS_PER_LINE+i], i == CHARS_PER_LINE-1);
               shown_img[ln*CHARS_PER_LINE+i] = pend_img[ln*CHARS_PER_LINE+i];
            end
            cur_dirty = 1'b1;
         end
      end
      if (cur_dirty || bus_err) begin
         push_cursor(cur_row, cur_col);
         cur_dirty = 1'b0;
      end
   endtask

   task automatic model_line_break();
      cur_col = '0;
      if (!dbl_height) cur_row = ~cur_row;
   endtask

   task automatic model_beat(input req_type r);
      int prior_cnt;
      prior_cnt = tx_expect_q.size();
      case (r.kind)
         KIND_CHAR: begin
            if (r.char_code == NEWLINE) begin
               for (int i = cur_col; i < CHARS_PER_LINE; i++)
                  pend_img[cur_row*CHARS_PER_LINE+i] = SPACE_CHAR;
               model_line_break();
            end else if (r.char_code >= PRINT_LO && r.char_code <= PRINT_HI) begin
               pend_img[cur_row*CHARS_PER_LINE+cur_col] = r.char_code;
               cur_col++;
               if (cur_col >= CHARS_PER_LINE) model_line_break();
            end
            if (r.end_of_text && auto_upd) model_update();
         end
         KIND_POS: begin
            if (r.row_sel < 2 && r.col_sel < CHARS_PER_LINE) begin
               cur_dirty = 1'b1;
               cur_row = r.row_sel[0];
               cur_col = r.col_sel;
               if (auto_upd) model_update();
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < TEXT_SIZE; i++) pend_img[i] = SPACE_CHAR;
            cur_row = 1'b0;
            cur_col = '0;
            if (auto_upd) model_update();
         end
         KIND_UPDATE: model_update();
         KIND_BUS: bus_err = r.bus_failed;
         default: ;
      endcase
      if (tx_expect_q.size() > prior_cnt) tx_expect_q[tx_expect_q.size()-1].last = 1'b1;
   endtask

   // response side and bookkeeping
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_char_lcd_shadow_text_engine_top: errors");
            $finish;
         end
         if (rsp_valid) begin
            bytes_out++;
            if (tx_expect_q.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h", rsp_data.tx_byte));
            end else begin
               want = tx_expect_q.pop_front();
               if (rsp_data.tx_byte !== want.tx_byte)
                  report_mismatch($sformatf("tx_byte %h want %h",
                                            rsp_data.tx_byte, want.tx_byte));
               if (rsp_data.end_of_transfer !== want.end_of_transfer)
                  report_mismatch($sformatf("end_of_transfer %b want %b",
                                            rsp_data.end_of_transfer, want.end_of_transfer));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last %b want %b", rsp_data.last, want.last));
            end
         end
         if (csr_we) begin
            if (csr_index == REG_DOUBLE_HEIGHT) dbl_height = csr_wdata[0];
            else if (csr_index == REG_AUTO_UPDATE) auto_upd = csr_wdata[0];
         end
         if (start && !busy) begin
            beats_in++;
            model_beat(req_data);
            took <= 1'b1;
         end else begin
            took <= 1'b0;
         end
         if (tx_expect_q.size() == 0 && !busy && !start && !csr_we) quiet++;
         else quiet = 0;
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request side, fed from the work queue
   always @(negedge clock) begin
      logic nstart;
      logic nwe;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         nstart = start;
         nwe = 1'b0;
         if (!(start && !took)) begin
            nstart = 1'b0;
            if (gap > 0) begin
               gap--;
            end else if (work_q.size() != 0) begin
               case (work_q[0].what)
                  ENT_REQ: begin
                     req_data <= work_q[0].r;
                     nstart = 1'b1;
                     void'(work_q.pop_front());
                     gap = pick_gap();
                  end
                  ENT_CSR: begin
                     if (quiet >= QUIET_CYC) begin
                        nwe = 1'b1;
                        csr_index <= work_q[0].idx;
                        csr_wdata <= work_q[0].val;
                        void'(work_q.pop_front());
                     end
                  end
                  default: begin
                     if (quiet >= QUIET_CYC) void'(work_q.pop_front());
                  end
               endcase
            end
         end
         start <= nstart;
         csr_we <= nwe;
      end
   end

   task automatic add_req(input logic [2:0] kind, input logic [7:0] ch, input logic eot,
                          input logic [1:0] row, input logic [5:0] col, input logic fail);
      work_type e;
      e.what = ENT_REQ;
      e.r = '{kind: kind, char_code: ch, end_of_text: eot, row_sel: row,
              col_sel: col, bus_failed: fail};
      e.idx = '0;
      e.val = '0;
      work_q.push_back(e);
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic val);
      work_type e;
      e.what = ENT_CSR;
      e.r = '0;
      e.idx = idx;
      e.val = val;
      work_q.push_back(e);
   endtask

   task automatic add_drain();
      work_type e;
      e.what = ENT_DRAIN;
      e.r = '0;
      e.idx = '0;
      e.val = '0;
      work_q.push_back(e);
   endtask

   task automatic add_random_phase(input int n);
      int p;
      int len;
      for (int k = 0; k < n; k++) begin
         p = $urandom_range(0, 99);
         if (p < 55) begin
            len = $urandom_range(1, 24);
            for (int j = 0; j < len; j++)
               add_req(KIND_CHAR, ($urandom_range(0, 9) == 0) ? NEWLINE
                       : 8'($urandom_range(32, 126)), j == len-1, 2'($urandom),
                       6'($urandom), 1'($urandom));
            k += len - 1;
         end else if (p < 65) begin
            add_req(KIND_POS, 8'($urandom), 1'($urandom), 2'($urandom_range(0, 1)),
                    6'($urandom_range(0, CHARS_PER_LINE-1)), 1'($urandom));
         end else if (p < 72) begin
            add_req(KIND_CLEAR, 8'($urandom), 1'($urandom), 2'($urandom), 6'($urandom),
                    1'($urandom));
         end else if (p < 82) begin
            add_req(KIND_UPDATE, 8'($urandom), 1'($urandom), 2'($urandom), 6'($urandom),
                    1'($urandom));
         end else if (p < 86) begin
            add_req(KIND_BUS, 8'($urandom), 1'($urandom), 2'($urandom), 6'($urandom),
                    $urandom_range(0, 3) == 0);
         end else begin
            add_req(3'($urandom), 8'($urandom), 1'($urandom), 2'($urandom), 6'($urandom),
                    1'($urandom));
         end
      end
      add_req(KIND_BUS, 8'h00, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(KIND_UPDATE, 8'h00, 1'b0, 2'd0, 6'd0, 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_data = '0;
      took = 1'b0;
      gap = 0;
      quiet = 0;
      cycles = 0;
      errors = 0;
      beats_in = 0;
      bytes_out = 0;
      for (int i = 0; i < TEXT_SIZE; i++) begin
         pend_img[i] = '0;
         shown_img[i] = '0;
      end
      cur_row = 1'b0;
      cur_col = '0;
      cur_dirty = 1'b0;
      bus_err = 1'b0;
      dbl_height = 1'b0;
      auto_upd = 1'b0;

      // directed
      add_csr(REG_DOUBLE_HEIGHT, 1'b0);
      add_csr(REG_AUTO_UPDATE, 1'b1);
      add_req(KIND_CHAR, 8'h20, 1'b0, 2'd3, 6'd63, 1'b1);
      add_req(KIND_CHAR, 8'h7E, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(KIND_CHAR, 8'h00, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(KIND_CHAR, 8'h1F, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(KIND_CHAR, 8'h7F, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(KIND_CHAR, 8'hFF, 1'b1, 2'd0, 6'd0, 1'b0);
      add_req(KIND_CHAR, NEWLINE, 1'b1, 2'd0, 6'd0, 1'b0);
      add_req(KIND_POS, 8'h00, 1'b0, 2'd1, 6'd19, 1'b0);
      add_req(KIND_POS, 8'h00, 1'b0, 2'd2, 6'd0, 1'b0);
      add_req(KIND_POS, 8'h00, 1'b0, 2'd3, 6'd5, 1'b0);
      add_req(KIND_POS, 8'h00, 1'b0, 2'd0, 6'd20, 1'b0);
      add_req(KIND_POS, 8'h00, 1'b0, 2'd0, 6'd63, 1'b0);
      add_req(KIND_CHAR, 8'h41, 1'b1, 2'd0, 6'd0, 1'b0);
      add_req(KIND_UPDATE, 8'h00, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(KIND_BUS, 8'h00, 1'b0, 2'd0, 6'd0, 1'b1);
      add_req(KIND_UPDATE, 8'h00, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(KIND_CLEAR, 8'h00, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(KIND_BUS, 8'h00, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(3'd5, 8'hFF, 1'b1, 2'd3, 6'd63, 1'b1);
      add_req(3'd6, 8'h00, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(3'd7, 8'h55, 1'b1, 2'd1, 6'd1, 1'b0);
      add_drain();
      add_csr(REG_DOUBLE_HEIGHT, 1'b1);
      add_req(KIND_CLEAR, 8'h00, 1'b0, 2'd0, 6'd0, 1'b0);
      add_req(KIND_CHAR, NEWLINE, 1'b1, 2'd0, 6'd0, 1'b0);

      // random phases across register settings
      add_random_phase(60);
      add_csr(REG_AUTO_UPDATE, 1'b0);
      add_random_phase(60);
      add_csr(REG_DOUBLE_HEIGHT, 1'b0);
      add_random_phase(60);
      add_csr(REG_AUTO_UPDATE, 1'b1);
      add_random_phase(60);
      add_drain();
      add_csr(REG_DOUBLE_HEIGHT, 1'b1);
      add_random_phase(50);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (work_q.size() == 0 && !start);
      wait (tx_expect_q.size() == 0);
      repeat (QUIET_CYC * 3) @(posedge clock);
      $display("run covered %0d request beats and %0d transfer bytes in %0d cycles",
               beats_in, bytes_out, cycles);
      $display("register settings toggled between phases, bus errors and drains included");
      if (errors == 0 && tx_expect_q.size() == 0) begin
         $display("tb_char_lcd_shadow_text_engine_top: clean");
      end else begin
         $display("%0d mismatches, %0d bytes still expected", errors, tx_expect_q.size());
         $display("tb_char_lcd_shadow_text_engine_top: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hdl/clse_pkg.sv
hdl/clse_ctrl.sv
hdl/clse_dpath.sv
hdl/char_lcd_shadow_text_engine_top.sv
hdl/clse_checker.sv
bench/tb_char_lcd_shadow_text_engine_top.sv
